/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL. Each macro expects clk in scope; ASSERT_CLK also expects rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, checked outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property, checked during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/tass_pkg.sv */
package tass_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int VALUE_W     = 10;
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_INDEX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_ATS        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_ACS        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OVERCURRENT_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_SECOND_TICKS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MS_TICKS          = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_MS        = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [9:0]  RST_OVERCURRENT_LIMIT = 10'd1000;
  localparam logic [13:0] RST_HALF_SECOND_TICKS = 14'd10000;
  localparam logic [4:0]  RST_MS_TICKS          = 5'd20;
  localparam logic [1:0]  RST_TIMEOUT_MS        = 2'd2;

  // Converter channels.
  localparam logic [1:0] CH_ATS = 2'd0;
  localparam logic [1:0] CH_ACS = 2'd1;
  localparam logic [1:0] CH_ATI = 2'd2;

  // Which reading was saved on a tick.
  localparam logic [1:0] SAVED_NONE = 2'd0;
  localparam logic [1:0] SAVED_ATI  = 2'd1;
  localparam logic [1:0] SAVED_ATS  = 2'd2;
  localparam logic [1:0] SAVED_ACS  = 2'd3;

  localparam logic [VALUE_W-1:0] FILTER_MAX = 10'd1000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] offset_ats;
    logic [SAMPLE_W-1:0] offset_acs;
    logic [VALUE_W-1:0]  overcurrent_limit;
    logic [13:0]         half_second_ticks;
    logic [4:0]          ms_ticks;
    logic [1:0]          timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic blink;
    logic half_second;
    logic ms;
    logic timeout;
  } tick_t;

  typedef struct packed {
    logic [1:0]         next_channel;
    logic [1:0]         saved_which;
    logic [VALUE_W-1:0] ati;
    logic [VALUE_W-1:0] ats;
    logic [VALUE_W-1:0] acs;
    logic               inhibit;
    logic               cut;
  } scan_t;

  // A sample below the offset sets the borrow bit, so a borrow reads as zero, as does a value above the clamp.
  function automatic logic [VALUE_W-1:0] filtered(input logic [SAMPLE_W-1:0] raw,
                                                  input logic [SAMPLE_W-1:0] offset);
    logic [SAMPLE_W:0] diff;
    diff = {1'b0, raw} - {1'b0, offset};
    if (diff[SAMPLE_W] || (diff[SAMPLE_W-1:2] > FILTER_MAX)) begin
      return '0;
    end
    return diff[SAMPLE_W-1:2];
  endfunction

endpackage

/* hdl/tass_if.sv */
interface tass_in_if;
  logic                         valid;
  logic                         ready;
  logic [tass_pkg::SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface tass_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   next_channel;
  logic [1:0]                   saved_which;
  logic [tass_pkg::VALUE_W-1:0] ati_value;
  logic [tass_pkg::VALUE_W-1:0] ats_value;
  logic [tass_pkg::VALUE_W-1:0] acs_value;
  logic                         blink_level;
  logic                         half_second_pulse;
  logic                         ms_pulse;
  logic                         timeout_pulse;
  logic                         pwm_inhibit;
  logic                         pwm_cut_pulse;

  modport source (output valid, output next_channel, output saved_which, output ati_value,
                  output ats_value, output acs_value, output blink_level,
                  output half_second_pulse, output ms_pulse, output timeout_pulse,
                  output pwm_inhibit, output pwm_cut_pulse, input ready);
  modport sink (input valid, input next_channel, input saved_which, input ati_value,
                input ats_value, input acs_value, input blink_level,
                input half_second_pulse, input ms_pulse, input timeout_pulse,
                input pwm_inhibit, input pwm_cut_pulse, output ready);
endinterface

/* hdl/tass_timer.sv */
module tass_timer (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  tass_pkg::cfg_t cfg,
  output tass_pkg::tick_t tick
);

  logic [13:0] hs_count, hs_count_next, hs_inc;
  logic [4:0]  ms_count, ms_count_next, ms_inc;
  logic [1:0]  to_count, to_count_next, to_inc;
  logic        blink, blink_next;
  logic        hs_hit, ms_hit, to_hit;

  // Counters compare after the increment; a tick count of zero hits on the wrap.
  always_comb begin
    hs_inc        = hs_count + 14'd1;
    hs_hit        = (hs_inc == cfg.half_second_ticks);
    hs_count_next = hs_hit ? 14'd0 : hs_inc;
    blink_next    = blink ^ hs_hit;

    ms_inc        = ms_count + 5'd1;
    ms_hit        = (ms_inc == cfg.ms_ticks);
    ms_count_next = ms_hit ? 5'd0 : ms_inc;

    to_inc        = to_count + 2'd1;
    to_hit        = ms_hit && (to_inc >= cfg.timeout_ms);
    to_count_next = ms_hit ? (to_hit ? 2'd0 : to_inc) : to_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hs_count <= '0;
      ms_count <= '0;
      to_count <= '0;
      blink    <= 1'b0;
    end else if (adv) begin
      hs_count <= hs_count_next;
      ms_count <= ms_count_next;
      to_count <= to_count_next;
      blink    <= blink_next;
    end
  end

  assign tick = '{blink: blink_next, half_second: hs_hit, ms: ms_hit, timeout: to_hit};

endmodule

/* hdl/tass_scan.sv */
`include "assert_macros.svh"

module tass_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [tass_pkg::SAMPLE_W-1:0] sample,
  input  tass_pkg::cfg_t                cfg,
  input  logic                          half_second,
  output tass_pkg::scan_t               res
);

  localparam logic [1:0] STEP_START = 2'd0;
  localparam logic [1:0] STEP_ATI   = 2'd1;
  localparam logic [1:0] STEP_ATS   = 2'd2;
  localparam logic [1:0] STEP_ACS   = 2'd3;

  logic [1:0]                  step, step_next;
  logic                        ati_request, ati_request_next;
  logic                        inhibit, inhibit_next;
  logic [tass_pkg::VALUE_W-1:0] ati, ati_next;
  logic [tass_pkg::VALUE_W-1:0] ats, ats_next;
  logic [tass_pkg::VALUE_W-1:0] acs, acs_next;
  logic [1:0]                  channel, saved;
  logic                        cut;
  logic                        request_now;

  always_comb begin
    // A request raised by the divider on this tick is already visible here.
    request_now      = ati_request | half_second;
    ati_request_next = request_now;
    step_next        = step;
    inhibit_next     = inhibit;
    ati_next         = ati;
    ats_next         = ats;
    acs_next         = acs;
    channel          = tass_pkg::CH_ATI;
    saved            = tass_pkg::SAVED_NONE;
    cut              = 1'b0;
    unique case (step)
      STEP_START: begin
        channel   = tass_pkg::CH_ATI;
        step_next = STEP_ATI;
      end
      STEP_ATI: begin
        ati_next         = sample[tass_pkg::SAMPLE_W-1:2];
        ati_request_next = 1'b0;
        saved            = tass_pkg::SAVED_ATI;
        channel          = tass_pkg::CH_ATS;
        step_next        = STEP_ATS;
      end
      STEP_ATS: begin
        ats_next  = tass_pkg::filtered(sample, cfg.offset_ats);
        saved     = tass_pkg::SAVED_ATS;
        channel   = tass_pkg::CH_ACS;
        step_next = STEP_ACS;
      end
      STEP_ACS: begin
        acs_next = tass_pkg::filtered(sample, cfg.offset_acs);
        saved    = tass_pkg::SAVED_ACS;
        if (acs_next > cfg.overcurrent_limit) begin
          inhibit_next = 1'b1;
          cut          = 1'b1;
        end
        if (request_now) begin
          channel   = tass_pkg::CH_ATI;
          step_next = STEP_ATI;
        end else begin
          channel   = tass_pkg::CH_ATS;
          step_next = STEP_ATS;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= STEP_START;
      ati_request <= 1'b0;
      inhibit     <= 1'b0;
      ati         <= '0;
      ats         <= '0;
      acs         <= '0;
    end else if (adv) begin
      step        <= step_next;
      ati_request <= ati_request_next;
      inhibit     <= inhibit_next;
      ati         <= ati_next;
      ats         <= ats_next;
      acs         <= acs_next;
    end
  end

  assign res = '{next_channel: channel, saved_which: saved, ati: ati_next, ats: ats_next,
                 acs: acs_next, inhibit: inhibit_next, cut: cut};

  // The start step is left once and never entered again until reset.
  `ASSERT_CLK(a_no_restart, (step != STEP_START) |=> (step != STEP_START), "scan step restarted")
  // The inhibit is sticky.
  `ASSERT_CLK(a_inhibit_sticky, inhibit |=> inhibit, "inhibit dropped without reset")

endmodule

/* hdl/tick_adc_scan_sequencer_unit.sv */
// Channel   Role  Handshake      Word
// adc       in    valid/ready    adc_sample: converter result of the previous tick
// result    out   valid/ready    channel, saved reading, readings, divider pulses, flags
// cfg       in    cfg_we only    cfg_index selects the register, cfg_data its value
//
// One word per clock is taken while the result register is not stalled; its result passes
// through the sample register and then the result register before it is valid.
// All state of one tick is updated in the cycle the word moves into the result register.
// Reset (rst, synchronous) clears dividers, scan step, readings, flags and both stages;
// configuration returns to its reset values.
// A stalled result register holds the sample stage; input ready drops only when both are
// full and the result word is not taken, or while rst is high.
`include "assert_macros.svh"

module tick_adc_scan_sequencer_unit #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  tass_in_if.sink                          adc,
  tass_out_if.source                       result,
  input  logic                             cfg_we,
  input  logic [tass_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tass_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tass_pkg::cfg_t  cfg;
  tass_pkg::tick_t tick;
  tass_pkg::scan_t scan;

  logic                          pipe_valid;
  logic [tass_pkg::SAMPLE_W-1:0] pipe_sample;
  logic [tass_pkg::SAMPLE_W-1:0] sample_used;
  logic                          out_valid;
  logic                          adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_ats        <= '0;
      cfg.offset_acs        <= '0;
      cfg.overcurrent_limit <= tass_pkg::RST_OVERCURRENT_LIMIT;
      cfg.half_second_ticks <= tass_pkg::RST_HALF_SECOND_TICKS;
      cfg.ms_ticks          <= tass_pkg::RST_MS_TICKS;
      cfg.timeout_ms        <= tass_pkg::RST_TIMEOUT_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tass_pkg::REG_OFFSET_ATS:        cfg.offset_ats        <= cfg_data[11:0];
        tass_pkg::REG_OFFSET_ACS:        cfg.offset_acs        <= cfg_data[11:0];
        tass_pkg::REG_OVERCURRENT_LIMIT: cfg.overcurrent_limit <= cfg_data[9:0];
        tass_pkg::REG_HALF_SECOND_TICKS: cfg.half_second_ticks <= cfg_data[13:0];
        tass_pkg::REG_MS_TICKS:          cfg.ms_ticks          <= cfg_data[4:0];
        tass_pkg::REG_TIMEOUT_MS:        cfg.timeout_ms        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // A word advances from the sample register when the result register is free or drains.
  assign adv       = pipe_valid && (!out_valid || result.ready);
  assign adc.ready = !rst && (!pipe_valid || adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (adc.ready) begin
      pipe_valid <= adc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adc.valid && adc.ready) begin
      pipe_sample <= adc.adc_sample;
    end
  end

  assign sample_used = tass_pkg::SAMPLE_W'(pipe_sample[SAMPLE_BITS-1:0]);

  tass_timer u_timer (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .cfg  (cfg),
    .tick (tick)
  );

  tass_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .sample      (sample_used),
    .cfg         (cfg),
    .half_second (tick.half_second),
    .res         (scan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.next_channel      <= scan.next_channel;
      result.saved_which       <= scan.saved_which;
      result.ati_value         <= scan.ati;
      result.ats_value         <= scan.ats;
      result.acs_value         <= scan.acs;
      result.blink_level       <= tick.blink;
      result.half_second_pulse <= tick.half_second;
      result.ms_pulse          <= tick.ms;
      result.timeout_pulse     <= tick.timeout;
      result.pwm_inhibit       <= scan.inhibit;
      result.pwm_cut_pulse     <= scan.cut;
    end
  end

  assign result.valid = out_valid;

  `ASSERT_CLK(a_cut_sets_inhibit, (out_valid && result.pwm_cut_pulse) |-> result.pwm_inhibit, "cut pulse without inhibit")
  `ASSERT_CLK(a_timeout_on_ms, (out_valid && result.timeout_pulse) |-> result.ms_pulse, "timeout pulse without millisecond pulse")
  `ASSERT_CLK(a_cut_on_acs, (out_valid && result.pwm_cut_pulse) |-> (result.saved_which == tass_pkg::SAVED_ACS), "cut pulse on a tick that saved no current")
  `ASSERT_ALWAYS(a_reset_empties, rst |=> (!pipe_valid && !out_valid), "pipeline not empty after reset")

endmodule
